### hdl/ip_range_to_asn_table_top_assert.svh
// Assertion macros for the IPv4 range to AS number table.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef IP_RANGE_TO_ASN_TABLE_TOP_ASSERT_SVH
`define IP_RANGE_TO_ASN_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPASN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPASN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ipasn_pkg.sv
// Package for the IPv4 range to AS number table: sizes, codes and types.
// Used by ip_range_to_asn_table_top and its testbench; no dependencies.
`timescale 1ns / 1ps

package ipasn_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ADDR_W      = 32;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_LOOKUP = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REVERSED = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISS     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_LK_RD,
    S_LK_CMP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [31:0]       asn;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### hdl/ipasn_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`timescale 1ns / 1ps

module ipasn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ip_range_to_asn_table_top.sv
// IPv4 range to AS number table: sorted insert, binary-search lookup, clear.
// Depends on ipasn_pkg, ipasn_ram and ip_range_to_asn_table_top_assert.svh.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_ready_o | func, range_low/high, as_number, addr
//   out     | output    | out_valid_o/out_ready_i | asn_out, status
//
// Clear, rejected insert and unused code pass from S_IDLE through S_FINISH to the output register.
// A lookup runs k search steps (at most 11 at 1024 entries) before S_FINISH;
// each step is one registered RAM read followed by one compare in the shared unit.
// An insert moving m entries up does one read and one write for each, then writes the new range.
// Reset empties the table at once (entry count to zero); no clearing pass is needed.
// The block takes one transaction at a time; the result waits in the output register
// while the next transaction is accepted, and a finished result stalls until it is free.
`timescale 1ns / 1ps

module ip_range_to_asn_table_top
  import ipasn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [31:0]       range_low_i,
  input  logic [31:0]       range_high_i,
  input  logic [31:0]       as_number_i,
  input  logic [31:0]       lookup_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       asn_out_o,
  output logic [1:0]        status_o
);

  `include "ip_range_to_asn_table_top_assert.svh"

  // Control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;

  // Working registers of the sequencer
  logic [ADDR_W-1:0] key_q, key_d;        // new range low on insert, address on lookup
  logic [ADDR_W-1:0] new_hi_q, new_hi_d;
  logic [31:0]       new_asn_q, new_asn_d;
  logic [IDX_W-1:0]  pos_q, pos_d;        // insert slot
  logic [CNT_W-1:0]  lo_q, lo_d;          // search bounds, end is exclusive
  logic [CNT_W-1:0]  end_q, end_d;
  logic [IDX_W-1:0]  mid_q, mid_d;
  logic [31:0]       res_asn_q, res_asn_d;
  status_e           res_status_q, res_status_d;
  logic [31:0]       asn_out_q, asn_out_d;
  status_e           status_q, status_d;

  // RAM port signals
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // Shared compare unit: key against the entry just read
  logic              key_gt_hi;
  logic              key_lt_lo;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  mid_calc;
  logic              accept;
  logic              out_free;
  func_e             func;

  assign func      = func_e'(func_i);
  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign key_gt_hi = key_q > ram_rdata.hi;
  assign key_lt_lo = key_q < ram_rdata.lo;

  // Midpoint over inclusive bounds [lo, end-1]; only used while lo < end
  assign span      = end_q - lo_q - CNT_W'(1);
  assign mid_calc  = lo_q + (span >> 1);

  ipasn_ram #(
    .Width (ENTRY_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign asn_out_o   = asn_out_q;
  assign status_o    = status_q;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (func == FN_INSERT && !(range_high_i < range_low_i) &&
              count_q != CNT_W'(TABLE_DEPTH)) begin
            state_d = S_INS_RD;
          end else if (func == FN_LOOKUP) begin
            state_d = S_LK_RD;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_INS_RD: begin
        state_d = (pos_q == '0) ? S_FINISH : S_INS_CMP;
      end
      S_INS_CMP: begin
        state_d = key_lt_lo ? S_INS_RD : S_FINISH;
      end
      S_LK_RD: begin
        state_d = (lo_q < end_q) ? S_LK_CMP : S_FINISH;
      end
      S_LK_CMP: begin
        state_d = (key_gt_hi || key_lt_lo) ? S_LK_RD : S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and output logic
  always_comb begin
    count_d      = count_q;
    key_d        = key_q;
    new_hi_d     = new_hi_q;
    new_asn_d    = new_asn_q;
    pos_d        = pos_q;
    lo_d         = lo_q;
    end_d        = end_q;
    mid_d        = mid_q;
    res_asn_d    = res_asn_q;
    res_status_d = res_status_q;
    asn_out_d    = asn_out_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = '{lo: key_q, hi: new_hi_q, asn: new_asn_q};
    ram_raddr    = mid_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_asn_d    = '0;
          res_status_d = ST_OK;
          key_d        = (func == FN_LOOKUP) ? lookup_addr_i : range_low_i;
          new_hi_d     = range_high_i;
          new_asn_d    = as_number_i;
          pos_d        = count_q[IDX_W-1:0];
          lo_d         = '0;
          end_d        = count_q;
          case (func)
            FN_CLEAR: begin
              count_d = '0;
            end
            FN_INSERT: begin
              if (range_high_i < range_low_i) begin
                res_status_d = ST_REVERSED;
              end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
                res_status_d = ST_FULL;
              end
            end
            FN_LOOKUP: begin
              res_status_d = ST_MISS;
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end
      S_INS_RD: begin
        // Empty slot at the bottom: place the new range there
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end else begin
          ram_raddr = pos_q - IDX_W'(1);
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (key_lt_lo) begin
          // Entry below sorts after the new range: move it up one slot
          ram_wdata = ram_rdata;
          pos_d     = pos_q - IDX_W'(1);
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      S_LK_RD: begin
        if (lo_q < end_q) begin
          ram_raddr = mid_calc[IDX_W-1:0];
          mid_d     = mid_calc[IDX_W-1:0];
        end
      end
      S_LK_CMP: begin
        if (key_gt_hi) begin
          lo_d = CNT_W'(mid_q) + CNT_W'(1);
        end else if (key_lt_lo) begin
          end_d = CNT_W'(mid_q);
        end else begin
          res_asn_d    = ram_rdata.asn;
          res_status_d = ST_OK;
        end
      end
      S_FINISH: begin
        // Hand the result over once the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          asn_out_d   = res_asn_q;
          status_d    = res_status_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    new_hi_q     <= new_hi_d;
    new_asn_q    <= new_asn_d;
    pos_q        <= pos_d;
    lo_q         <= lo_d;
    end_q        <= end_d;
    mid_q        <= mid_d;
    res_asn_q    <= res_asn_d;
    res_status_q <= res_status_d;
    asn_out_q    <= asn_out_d;
    status_q     <= status_d;
  end

  // Checks on the table control
  `IPASN_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "entry count overflow")
  `IPASN_ASSERT_NEXT(a_clear_empties, accept && func == FN_CLEAR, count_q == '0, "clear missed")
  `IPASN_ASSERT_NOW(a_write_in_insert, ram_we, state_q == S_INS_RD || state_q == S_INS_CMP,
                    "table write outside insert")
  `IPASN_ASSERT_NOW(a_bounds_order, state_q == S_LK_RD || state_q == S_LK_CMP,
                    lo_q <= end_q && end_q <= count_q, "search bounds crossed")

endmodule

### tb/tb_ip_range_to_asn_table_top.sv
// Self-checking bench for ip_range_to_asn_table_top: clear, sorted insert, binary-search lookup.
// Depends on ipasn_pkg for sizes, codes and the entry layout; needs nothing but the RTL.
`timescale 1ns / 1ps

module tb_ip_range_to_asn_table_top;
  import ipasn_pkg::*;

  // Spare operation code: the block must answer it with a plain done status.
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // Slowest run with this stimulus: about 1800 transactions, each adding its own
  // block work (a small table shifting), a sender gap and a receiver stall.
  // CYCLE_LIMIT allows several times that sum.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Spare cycles after the last result, to catch a stray extra one.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 700;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] asn;
    logic [31:0] addr;
    bit          drain_first;  // hold this transaction until all results are back
  } table_op_t;

  typedef struct {
    logic [31:0] asn;
    status_e     status;
  } table_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func = FN_CLEAR;
  logic [31:0] range_low = '0;
  logic [31:0] range_high = '0;
  logic [31:0] as_number = '0;
  logic [31:0] lookup_addr = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [31:0] asn_out_o;
  logic [1:0]  status_o;

  // Transactions still to be sent, and results owed by the block, oldest first.
  table_op_t    pending_ops[$];
  table_reply_t awaited_replies[$];

  // Shadow copy of the table, kept in step with accepted transactions.
  entry_t      held_ranges[TABLE_DEPTH];
  int unsigned held_count = 0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  always #4 clk_i = ~clk_i;

  ip_range_to_asn_table_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .func_i       (func),
    .range_low_i  (range_low),
    .range_high_i (range_high),
    .as_number_i  (as_number),
    .lookup_addr_i(lookup_addr),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .asn_out_o    (asn_out_o),
    .status_o     (status_o)
  );

  // Apply one transaction to the shadow table and return the answer it earns.
  // The search walks inclusive bounds with a floor midpoint, so overlapping
  // ranges resolve to whichever matching entry the walk meets first.
  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t reply;
    int unsigned  pos;
    int unsigned  lo_i;
    int unsigned  end_i;
    int unsigned  mid;
    bit           hit;
    reply.asn    = '0;
    reply.status = ST_OK;
    case (op.func)
      FN_CLEAR: begin
        held_count = 0;
      end
      FN_INSERT: begin
        if (op.hi < op.lo) begin
          reply.status = ST_REVERSED;
        end else if (held_count >= TABLE_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          // Shift larger lows up one place; equal lows stay ahead of the new entry.
          pos = held_count;
          while (pos > 0 && held_ranges[pos-1].lo > op.lo) begin
            held_ranges[pos] = held_ranges[pos-1];
            pos--;
          end
          held_ranges[pos].lo  = op.lo;
          held_ranges[pos].hi  = op.hi;
          held_ranges[pos].asn = op.asn;
          held_count++;
        end
      end
      FN_LOOKUP: begin
        lo_i  = 0;
        end_i = held_count;
        hit   = 1'b0;
        while (!hit && lo_i < end_i) begin
          mid = lo_i + ((end_i - 1 - lo_i) >> 1);
          if (op.addr > held_ranges[mid].hi) begin
            lo_i = mid + 1;
          end else if (op.addr < held_ranges[mid].lo) begin
            end_i = mid;
          end else begin
            hit       = 1'b1;
            reply.asn = held_ranges[mid].asn;
          end
        end
        if (!hit) begin
          reply.status = ST_MISS;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  // Mostly short gaps, now and then a long one; none during a calm stretch.
  function automatic int unsigned idle_len(input int unsigned calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm > 0 || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_op(input logic [1:0] f, input logic [31:0] lo, input logic [31:0] hi,
                        input logic [31:0] asn, input logic [31:0] addr, input bit drain);
    table_op_t op;
    op.func        = f;
    op.lo          = lo;
    op.hi          = hi;
    op.asn         = asn;
    op.addr        = addr;
    op.drain_first = drain;
    pending_ops.push_back(op);
  endtask

  // Fields that the operation does not use carry random bits all the same.
  task automatic add_insert(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] asn);
    add_op(FN_INSERT, lo, hi, asn, $urandom, 1'b0);
  endtask

  task automatic add_lookup(input logic [31:0] addr);
    add_op(FN_LOOKUP, $urandom, $urandom, $urandom, addr, 1'b0);
  endtask

  task automatic add_clear(input bit drain);
    add_op(FN_CLEAR, $urandom, $urandom, $urandom, $urandom, drain);
  endtask

  // Driver: present queued transactions, hold each until accepted, predict on
  // acceptance. Valid and payload get at most one assignment per edge.
  int unsigned send_idle = 0;
  int unsigned send_calm = 0;
  table_op_t   current_op;

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    bit accepted;
    bit can_load;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      send_idle = 0;
    end else begin
      accepted = in_valid && in_ready_o;
      if (accepted) begin
        awaited_replies.push_back(apply_table_op(current_op));
        if (send_calm > 0) begin
          send_calm--;
        end else if ($urandom_range(0, 49) == 0) begin
          send_calm = $urandom_range(20, 60);
        end
        send_idle = idle_len(send_calm);
      end else if (!in_valid && send_idle > 0) begin
        send_idle--;
      end
      can_load = (accepted || !in_valid) && send_idle == 0 && pending_ops.size() > 0;
      // Hold off a draining transaction until the block owes nothing.
      if (can_load && pending_ops[0].drain_first && awaited_replies.size() > 0) begin
        can_load = 1'b0;
      end
      if (can_load) begin
        current_op  = pending_ops.pop_front();
        in_valid    <= 1'b1;
        func        <= current_op.func;
        range_low   <= current_op.lo;
        range_high  <= current_op.hi;
        as_number   <= current_op.asn;
        lookup_addr <= current_op.addr;
      end else if (accepted) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stall the result channel at random and check each accepted result
  // against the oldest prediction.
  int unsigned sink_stall = 0;
  int unsigned sink_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin : collect_replies
    table_reply_t want;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected result: asn_out %h status %0d", asn_out_o, status_o);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (asn_out_o !== want.asn) begin
            $error("asn_out mismatch: expected %h, actual %h", want.asn, asn_out_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
            fail_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (sink_calm > 0) begin
          sink_calm--;
        end else if ($urandom_range(0, 59) == 0) begin
          sink_calm = $urandom_range(30, 80);
        end
        sink_stall = idle_len(sink_calm);
      end
    end
  end

  // Watchdog: drop out with a failure if the run is still going when the cycle counter reaches CYCLE_LIMIT.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, awaited_replies.size());
      $display("ip_range_to_asn_table_top test failed");
      $finish;
    end
  end

  initial begin : run_test
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] made_lo[$];
    logic [31:0] made_hi[$];
    bit          slot_taken[64];
    int unsigned slot;
    int unsigned n_ins;
    int unsigned n_look;
    int unsigned idx;
    int unsigned roll;
    int unsigned start_size;

    // Directed part: empty table, edge addresses, zero AS number, equal lows,
    // out-of-order insert, reversed range, spare code, then clear.
    add_lookup(32'h0000_0000);                               // empty table misses
    add_insert(32'h0000_0001, 32'h0000_0000, 32'h1234_5678); // reversed, ignored
    add_insert(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    add_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000); // AS number zero
    add_insert(32'h0A00_0000, 32'h0AFF_FFFF, 32'h0000_FC00);
    add_insert(32'h0A00_0000, 32'h0A00_00FF, 32'h0000_0007); // equal low, overlaps
    add_insert(32'h0500_0000, 32'h0500_00FF, 32'h0000_0005); // lands below others
    add_insert(32'h8000_0000, 32'hBFFF_FFFF, 32'h8000_0001);
    add_lookup(32'h0000_0000);
    add_lookup(32'hFFFF_FFFF);                               // hit with AS number zero
    add_lookup(32'h0A00_0010);
    add_lookup(32'h0A80_0000);
    add_lookup(32'h0A00_00FF);
    add_lookup(32'h0500_0080);
    add_lookup(32'h0600_0000);                               // gap between ranges
    add_lookup(32'hBFFF_FFFF);
    add_lookup(32'hC000_0000);
    add_op(FN_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_clear(1'b0);
    add_lookup(32'h0A00_0010);                               // gone after clear

    // Fill to capacity with ascending lows so every insert appends, then
    // probe a full table: a dropped insert, a reversed one, and lookups.
    add_clear(1'b1);
    made_lo.delete();
    made_hi.delete();
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      lo = i << 22;
      hi = lo + $urandom_range(0, (1 << 22) - 1);
      made_lo.push_back(lo);
      made_hi.push_back(hi);
      add_insert(lo, hi, $urandom);
      if (i % 64 == 63) begin
        add_lookup(made_lo[$urandom_range(0, i)]);
      end
    end
    add_insert(32'h0000_0000, 32'hFFFF_FFFF, $urandom);      // full, dropped
    add_insert(32'hFFFF_FFFF, 32'h0000_0000, $urandom);      // reversed wins over full
    add_lookup(32'h0000_0000);
    add_lookup(32'hFFFF_FFFF);
    for (int unsigned i = 0; i < 30; i++) begin
      idx = $urandom_range(0, TABLE_DEPTH - 1);
      roll = $urandom_range(0, 3);
      case (roll)
        0: add_lookup(made_lo[idx]);
        1: add_lookup(made_hi[idx]);
        2: add_lookup(made_hi[idx] + 1);
        default: add_lookup($urandom);
      endcase
    end

    // Random part: short scenarios of well-formed sorted-table traffic on
    // fresh tables, with reversed inserts, wild inserts and spare codes mixed in.
    start_size = pending_ops.size();
    while (pending_ops.size() < start_size + RANDOM_ITEMS) begin
      add_clear($urandom_range(0, 5) == 0);
      made_lo.delete();
      made_hi.delete();
      foreach (slot_taken[s]) slot_taken[s] = 1'b0;
      n_ins  = $urandom_range(1, 48);
      n_look = $urandom_range(5, 30);
      for (int unsigned i = 0; i < n_ins; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          add_insert($urandom, $urandom, $urandom);           // may overlap or reverse
        end else if (roll < 16) begin
          hi = $urandom_range(0, 32'hFFFF_FFFE);
          add_insert(hi + $urandom_range(1, 1000), hi, $urandom);
        end else if (roll < 19) begin
          add_op(FN_UNUSED, $urandom, $urandom, $urandom, $urandom, 1'b0);
        end else begin
          // One range per 64 Mi slot, slots taken in random order.
          do slot = $urandom_range(0, 63); while (slot_taken[slot]);
          slot_taken[slot] = 1'b1;
          lo = (slot << 26) + $urandom_range(0, 1 << 20);
          roll = $urandom_range(0, 9);
          if (roll < 3) hi = lo + $urandom_range(0, 255);
          else if (roll < 4) hi = lo;
          else hi = lo + $urandom_range(0, 1 << 24);
          made_lo.push_back(lo);
          made_hi.push_back(hi);
          add_insert(lo, hi, $urandom);
        end
        if ($urandom_range(0, 3) == 0) begin
          add_lookup($urandom);
        end
      end
      for (int unsigned i = 0; i < n_look; i++) begin
        roll = $urandom_range(0, 99);
        if (made_lo.size() == 0 || roll >= 85) begin
          add_lookup($urandom);
        end else begin
          idx = $urandom_range(0, made_lo.size() - 1);
          if (roll < 40) add_lookup(made_lo[idx] + $urandom_range(0, made_hi[idx] - made_lo[idx]));
          else if (roll < 55) add_lookup(made_lo[idx]);
          else if (roll < 70) add_lookup(made_hi[idx]);
          else if (roll < 80) add_lookup(made_hi[idx] + 1);
          else add_lookup(made_lo[idx] - 1);
        end
      end
    end

    // Reset once, then let the driver and monitor run the queue dry.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_ops.size() > 0 || in_valid || awaited_replies.size() > 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ip_range_to_asn_table_top test passed");
    end else begin
      $display("ip_range_to_asn_table_top test failed");
    end
    $finish;
  end

endmodule
